@@ src/ppdr_pkg.sv @@
// Shared types, widths and constants of the PID PWM delay regulator.
`default_nettype none
package ppdr_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int ERR_W      = SAMPLE_W + 1;
  localparam int DIFF_W     = ERR_W + 1;
  localparam int GAIN_W     = 16;
  localparam int TIME_W     = 16;
  localparam int INT_W      = 32;
  localparam int PINT_W     = TIME_W + 1 + ERR_W;
  localparam int PDER_W     = TIME_W + 1 + DIFF_W;
  localparam int PPROP_W    = GAIN_W + ERR_W;
  localparam int PROP_SH    = 8;
  localparam int TI_W       = GAIN_W + INT_W;
  localparam int TD_W       = GAIN_W + PDER_W;
  localparam int INNER_W    = 48;
  localparam int HALF_W     = INNER_W / 2;
  localparam int PLO_W      = GAIN_W + HALF_W + 1;
  localparam int PHI_W      = GAIN_W + HALF_W;
  localparam int FULL_W     = 64;
  localparam int FRAC_W     = 32;
  localparam int CORR_W     = FULL_W - FRAC_W + 1;
  localparam int DSUM_W     = CORR_W + 1;
  localparam int DELAY_W    = 16;
  localparam int CORR_OUT_W = 6;
  localparam int IDX_W      = 3;
  localparam int DATA_W     = 16;

  localparam int CORRECTION_LIMIT = 30;
  localparam logic signed [DELAY_W-1:0] DELAY_RESET = 16'sd0;

  localparam logic signed [FULL_W-1:0] FULL_LIM  = {32'(CORRECTION_LIMIT), 32'd0};
  localparam logic signed [FULL_W-1:0] FULL_HALF = 64'sh0000_0000_8000_0000;
  localparam logic signed [INT_W-1:0]  INT_MAX   = 32'sh7fff_ffff;
  localparam logic signed [INT_W-1:0]  INT_MIN   = 32'sh8000_0000;
  localparam logic signed [DELAY_W-1:0] DELAY_MAX = 16'sh7fff;
  localparam logic signed [DELAY_W-1:0] DELAY_MIN = 16'sh8000;

  localparam logic KIND_STEP  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef enum logic [IDX_W-1:0] {
    REG_SETPOINT,
    REG_TOTAL_GAIN,
    REG_PROP_GAIN,
    REG_INTEG_GAIN,
    REG_DERIV_GAIN,
    REG_THRESHOLD,
    REG_PERIOD,
    REG_INV_PERIOD
  } cfg_idx_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] setpoint;
    logic [GAIN_W-1:0]   total_gain;
    logic [GAIN_W-1:0]   prop_gain;
    logic [GAIN_W-1:0]   integ_gain;
    logic [GAIN_W-1:0]   deriv_gain;
    logic [SAMPLE_W-1:0] threshold;
    logic [TIME_W-1:0]   period;
    logic [TIME_W-1:0]   inv_period;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_INTEG,
    ST_MUL2,
    ST_SUM,
    ST_MULT,
    ST_FULL,
    ST_ROUND,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic clear;
    logic mul1;
    logic integ;
    logic mul2;
    logic sum;
    logic mult;
    logic full;
    logic round;
    logic out_load;
  } dp_cmd_t;

endpackage
`default_nettype wire

@@ src/pid_pwm_delay_regulator_top.sv @@
// Top level of the PID PWM delay regulator.
//
// Input channel (in_valid/in_stall, kind, adc_sample): a transaction with kind
// step runs one PID update; kind clear zeroes the integral and previous error
// in the accepting cycle and produces no result.
// Output channel (out_valid/out_stall, correction, pwm_delay, in_band): one
// transaction per step, held in an output register until taken.
// Configuration: wr_en/wr_index/wr_data write one register per cycle; write
// only while no step is in flight.
// Timing: a step passes a sequencer of nine states, one multiply or wide add
// per state between IDLE and DONE; out_valid rises as the step leaves DONE and
// in_stall drops in the same cycle; a new step waits until the last is done. The
// 64-bit product with total_gain is split into two 16x24 partial products.
// Clear transactions are taken back to back.
// Stall: if the previous result is still stalled, the finished step waits in
// its last state, holding in_stall high, until the output register frees.
// Reset: synchronous; clears the integral, previous error, first-step flag,
// sets the delay to its reset value and the registers to their reset values.
`default_nettype none
module pid_pwm_delay_regulator_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   wr_en,
  input  logic [ppdr_pkg::IDX_W-1:0]             wr_index,
  input  logic [ppdr_pkg::DATA_W-1:0]            wr_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   kind,
  input  logic [ppdr_pkg::SAMPLE_W-1:0]          adc_sample,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [ppdr_pkg::CORR_OUT_W-1:0] correction,
  output logic signed [ppdr_pkg::DELAY_W-1:0]    pwm_delay,
  output logic                                   in_band
);
  import ppdr_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;

  ppdr_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  ppdr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .kind      (kind),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  ppdr_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .adc_sample (adc_sample),
    .correction (correction),
    .pwm_delay  (pwm_delay),
    .in_band    (in_band)
  );

endmodule
`default_nettype wire

@@ src/ppdr_cfg.sv @@
// Configuration register file of the PID PWM delay regulator.
`default_nettype none
module ppdr_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [ppdr_pkg::IDX_W-1:0] wr_index,
  input  logic [ppdr_pkg::DATA_W-1:0] wr_data,
  output ppdr_pkg::cfg_t             cfg
);
  import ppdr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint   <= '0;
      cfg.total_gain <= '0;
      cfg.prop_gain  <= '0;
      cfg.integ_gain <= '0;
      cfg.deriv_gain <= '0;
      cfg.threshold  <= '0;
      cfg.period     <= 16'd256;
      cfg.inv_period <= 16'd256;
    end else if (wr_en) begin
      case (cfg_idx_t'(wr_index))
        REG_SETPOINT:   cfg.setpoint   <= wr_data[SAMPLE_W-1:0];
        REG_TOTAL_GAIN: cfg.total_gain <= wr_data[GAIN_W-1:0];
        REG_PROP_GAIN:  cfg.prop_gain  <= wr_data[GAIN_W-1:0];
        REG_INTEG_GAIN: cfg.integ_gain <= wr_data[GAIN_W-1:0];
        REG_DERIV_GAIN: cfg.deriv_gain <= wr_data[GAIN_W-1:0];
        REG_THRESHOLD:  cfg.threshold  <= wr_data[SAMPLE_W-1:0];
        REG_PERIOD:     cfg.period     <= wr_data[TIME_W-1:0];
        REG_INV_PERIOD: cfg.inv_period <= wr_data[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ src/ppdr_ctrl.sv @@
// Sequencer of the PID PWM delay regulator: steps the datapath and owns the handshakes.
`default_nettype none
module ppdr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              kind,
  input  logic              out_stall,
  output logic              in_stall,
  output logic              out_valid,
  output ppdr_pkg::dp_cmd_t cmd
);
  import ppdr_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (kind == KIND_CLEAR) begin
            cmd.clear = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            state_next  = ST_MUL1;
          end
        end
      end
      ST_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = ST_INTEG;
      end
      ST_INTEG: begin
        cmd.integ  = 1'b1;
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_MULT;
      end
      ST_MULT: begin
        cmd.mult   = 1'b1;
        state_next = ST_FULL;
      end
      ST_FULL: begin
        cmd.full   = 1'b1;
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round  = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // output register: holds until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ src/ppdr_dp.sv @@
// Datapath of the PID PWM delay regulator: error, integral, PID products, rounding, delay.
`default_nettype none
module ppdr_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  ppdr_pkg::cfg_t                         cfg,
  input  ppdr_pkg::dp_cmd_t                      cmd,
  input  logic [ppdr_pkg::SAMPLE_W-1:0]          adc_sample,
  output logic signed [ppdr_pkg::CORR_OUT_W-1:0] correction,
  output logic signed [ppdr_pkg::DELAY_W-1:0]    pwm_delay,
  output logic                                   in_band
);
  import ppdr_pkg::*;

  // loop state
  logic signed [INT_W-1:0]   integral;
  logic signed [ERR_W-1:0]   prev_err;
  logic                      started;
  logic signed [DELAY_W-1:0] delay;

  // per-step working registers
  logic signed [ERR_W-1:0]   err;
  logic                      band;
  logic signed [DIFF_W-1:0]  diff;
  logic                      deriv_en;
  logic signed [PINT_W-1:0]  p_int;
  logic signed [PDER_W-1:0]  p_der;
  logic signed [PPROP_W-1:0] p_prop;
  logic signed [TI_W-1:0]    t_i;
  logic signed [TD_W-1:0]    t_d;
  logic signed [INNER_W-1:0] inner;
  logic signed [PLO_W-1:0]   p_lo;
  logic signed [PHI_W-1:0]   p_hi;
  logic signed [FULL_W-1:0]  full;
  logic signed [CORR_W-1:0]  corr;

  logic signed [ERR_W-1:0]   err_now;
  logic        [ERR_W-1:0]   mag_now;
  logic                      band_now;
  logic signed [DIFF_W-1:0]  diff_now;
  logic signed [INT_W:0]     isum;
  logic signed [INT_W-1:0]   isum_sat;
  logic signed [FULL_W-1:0]  full_sum;
  logic signed [FULL_W-1:0]  full_clamp;
  logic signed [FULL_W-1:0]  rnd;
  logic                      rnd_up;
  logic signed [CORR_W-1:0]  corr_now;
  logic signed [DSUM_W-1:0]  dsum;
  logic signed [DELAY_W-1:0] delay_next;

  always_comb begin
    err_now  = $signed({1'b0, adc_sample}) - $signed({1'b0, cfg.setpoint});
    mag_now  = err_now[ERR_W-1] ? ERR_W'(-err_now) : ERR_W'(err_now);
    band_now = (mag_now < {1'b0, cfg.threshold});
    diff_now = DIFF_W'(err_now) - DIFF_W'(prev_err);

    isum = (INT_W+1)'(integral) + (INT_W+1)'(p_int);
    if (isum[INT_W] != isum[INT_W-1]) begin
      isum_sat = isum[INT_W] ? INT_MIN : INT_MAX;
    end else begin
      isum_sat = isum[INT_W-1:0];
    end

    full_sum = (FULL_W'(p_hi) <<< HALF_W) + FULL_W'(p_lo);
    if (full_sum > FULL_LIM) begin
      full_clamp = FULL_LIM;
    end else if (full_sum < -FULL_LIM) begin
      full_clamp = -FULL_LIM;
    end else begin
      full_clamp = full_sum;
    end

    // +0.5 then truncate toward zero
    rnd      = full + FULL_HALF;
    rnd_up   = rnd[FULL_W-1] && (rnd[FRAC_W-1:0] != '0);
    corr_now = CORR_W'(rnd >>> FRAC_W) + $signed({{(CORR_W-1){1'b0}}, rnd_up});

    dsum = DSUM_W'(delay) + DSUM_W'(corr);
    if (dsum > DSUM_W'(DELAY_MAX)) begin
      delay_next = DELAY_MAX;
    end else if (dsum < DSUM_W'(DELAY_MIN)) begin
      delay_next = DELAY_MIN;
    end else begin
      delay_next = dsum[DELAY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral <= '0;
      prev_err <= '0;
      started  <= 1'b0;
      delay    <= DELAY_RESET;
    end else begin
      if (cmd.clear) begin
        integral <= '0;
        prev_err <= '0;
      end
      if (cmd.capture) begin
        prev_err <= err_now;
        started  <= 1'b1;
      end
      if (cmd.integ) begin
        integral <= band ? isum_sat : '0;
      end
      if (cmd.out_load) begin
        delay <= delay_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      err      <= err_now;
      band     <= band_now;
      diff     <= diff_now;
      deriv_en <= started;
    end
    if (cmd.mul1) begin
      p_int  <= $signed({1'b0, cfg.period}) * err;
      if (deriv_en) begin
        p_der <= $signed({1'b0, cfg.inv_period}) * diff;
      end else begin
        p_der <= '0;
      end
      p_prop <= $signed(cfg.prop_gain) * err;
    end
    if (cmd.mul2) begin
      t_i <= $signed(cfg.integ_gain) * integral;
      t_d <= $signed(cfg.deriv_gain) * p_der;
    end
    if (cmd.sum) begin
      inner <= INNER_W'(t_i) + INNER_W'(t_d) + (INNER_W'(p_prop) <<< PROP_SH);
    end
    if (cmd.mult) begin
      p_lo <= $signed(cfg.total_gain) * $signed({1'b0, inner[HALF_W-1:0]});
      p_hi <= $signed(cfg.total_gain) * $signed(inner[INNER_W-1:HALF_W]);
    end
    if (cmd.full) begin
      full <= full_clamp;
    end
    if (cmd.round) begin
      corr <= corr_now;
    end
    if (cmd.out_load) begin
      correction <= corr[CORR_OUT_W-1:0];
      pwm_delay  <= delay_next;
      in_band    <= band;
    end
  end

endmodule
`default_nettype wire

@@ src/ppdr_chk.sv @@
// Port-level checker of the PID PWM delay regulator and its bind.
`default_nettype none
module ppdr_chk (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   in_valid,
  input logic                                   in_stall,
  input logic                                   kind,
  input logic                                   out_valid,
  input logic                                   out_stall,
  input logic signed [ppdr_pkg::CORR_OUT_W-1:0] correction
);
  import ppdr_pkg::*;

  // a step transaction occupies the sequencer
  a_step_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (kind == KIND_STEP) |=> in_stall)
    else $error("input not stalled after a step transaction");

  // a clear transaction leaves the input open
  a_clear_open: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (kind == KIND_CLEAR) |=> !in_stall)
    else $error("input stalled after a clear transaction");

  // a new result only comes out of a running step
  a_result_from_step: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a step in flight");

  // correction stays inside the clamp
  a_corr_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (correction <= CORR_OUT_W'(CORRECTION_LIMIT)) &&
                  (correction >= -CORR_OUT_W'(CORRECTION_LIMIT)))
    else $error("correction outside the limit");

  // stalled result is held
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(correction))
    else $error("stalled result dropped or changed");

endmodule

bind pid_pwm_delay_regulator_top ppdr_chk u_chk (.*);
`default_nettype wire

@@ tb/pid_pwm_delay_regulator_top_tb.sv @@
// Self-checking testbench for the PID PWM delay regulator with a fixed-point step predictor.
module pid_pwm_delay_regulator_top_tb;
  import ppdr_pkg::*;

  typedef struct packed {
    logic                kind;
    logic [SAMPLE_W-1:0] sample;
  } ctrl_txn_t;

  typedef struct packed {
    logic signed [CORR_OUT_W-1:0] corr;
    logic signed [DELAY_W-1:0]    delay;
    logic                         band;
  } delay_update_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         wr_en = 1'b0;
  logic [IDX_W-1:0]             wr_index = '0;
  logic [DATA_W-1:0]            wr_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         kind = KIND_STEP;
  logic [SAMPLE_W-1:0]          adc_sample = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [CORR_OUT_W-1:0] correction;
  logic signed [DELAY_W-1:0]    pwm_delay;
  logic                         in_band;

  pid_pwm_delay_regulator_top uut (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .adc_sample (adc_sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .correction (correction),
    .pwm_delay  (pwm_delay),
    .in_band    (in_band)
  );

  // register shadow
  logic [SAMPLE_W-1:0]      sp_reg = '0;
  logic signed [GAIN_W-1:0] tg_reg = '0;
  logic signed [GAIN_W-1:0] pg_reg = '0;
  logic signed [GAIN_W-1:0] ig_reg = '0;
  logic signed [GAIN_W-1:0] dg_reg = '0;
  logic [SAMPLE_W-1:0]      thr_reg = '0;
  logic [TIME_W-1:0]        st_reg = 16'd256;
  logic [TIME_W-1:0]        ist_reg = 16'd256;

  // controller state
  longint integ_acc = 0;
  longint prev_err = 0;
  longint delay_acc = longint'(DELAY_RESET);
  bit     started = 1'b0;

  ctrl_txn_t     txn_q[$];
  delay_update_t delay_updates[$];
  int            mismatches = 0;

  ctrl_txn_t     nxt_txn;
  int            burst_left = 0;
  int            gap_left = 0;

  delay_update_t want;
  int            results_seen = 0;
  int            hold_left = 0;
  int            stall_mode = 0;
  int            cyc = 0;
  logic          stall_next;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic predict_update(input logic k, input logic [SAMPLE_W-1:0] smp);
    longint        err;
    longint        mag;
    longint        deriv;
    longint        inner;
    longint        full;
    longint        corr;
    bit            band;
    delay_update_t upd;
    if (k == KIND_CLEAR) begin
      integ_acc = 0;
      prev_err = 0;
    end else begin
      err = longint'(smp) - longint'(sp_reg);
      mag = (err < 0) ? -err : err;
      band = mag < longint'(thr_reg);
      if (band) begin
        integ_acc = integ_acc + longint'(st_reg) * err;
        if (integ_acc > longint'(INT_MAX)) integ_acc = longint'(INT_MAX);
        if (integ_acc < longint'(INT_MIN)) integ_acc = longint'(INT_MIN);
      end else begin
        integ_acc = 0;
      end
      deriv = started ? (err - prev_err) * longint'(ist_reg) : 0;
      started = 1'b1;
      prev_err = err;
      inner = longint'(pg_reg) * err * 256 + longint'(ig_reg) * integ_acc
            + longint'(dg_reg) * deriv;
      full = longint'(tg_reg) * inner;
      if (full > FULL_LIM) full = FULL_LIM;
      if (full < -FULL_LIM) full = -FULL_LIM;
      full = full + FULL_HALF;
      corr = (full >= 0) ? (full >>> FRAC_W) : -((-full) >>> FRAC_W);
      delay_acc = delay_acc + corr;
      if (delay_acc > longint'(DELAY_MAX)) delay_acc = longint'(DELAY_MAX);
      if (delay_acc < longint'(DELAY_MIN)) delay_acc = longint'(DELAY_MIN);
      upd.corr = corr[CORR_OUT_W-1:0];
      upd.delay = delay_acc[DELAY_W-1:0];
      upd.band = band;
      delay_updates.push_back(upd);
    end
  endtask

  // sender: bursts with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_update(kind, adc_sample);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (txn_q.size() > 0) begin
          nxt_txn = txn_q.pop_front();
          in_valid <= 1'b1;
          kind <= nxt_txn.kind;
          adc_sample <= nxt_txn.sample;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks results, stalls on its own pattern, one long hold-off now and then
  always @(posedge clk) begin
    if (!rst) begin
      cyc++;
      if (out_valid && !out_stall) begin
        if (delay_updates.size() == 0) begin
          flag_mismatch("result transaction with nothing expected");
        end else begin
          want = delay_updates.pop_front();
          if (correction !== want.corr)
            flag_mismatch($sformatf("correction got %0d want %0d", correction, want.corr));
          if (pwm_delay !== want.delay)
            flag_mismatch($sformatf("pwm_delay got %0d want %0d", pwm_delay, want.delay));
          if (in_band !== want.band)
            flag_mismatch($sformatf("in_band got %0b want %0b", in_band, want.band));
        end
        results_seen++;
        if (results_seen == 40 || results_seen == 1500) hold_left = 300;
      end
      if (cyc % 64 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else begin
        case (stall_mode)
          0: stall_next = 1'b0;
          1: stall_next = ($urandom_range(0, 3) == 0);
          2: stall_next = ($urandom_range(0, 3) != 0);
          default: stall_next = (cyc % 8) < 5;
        endcase
      end
      out_stall <= stall_next;
    end
  end

  task automatic queue_step(input logic [SAMPLE_W-1:0] s);
    txn_q.push_back('{KIND_STEP, s});
  endtask

  task automatic queue_clear();
    txn_q.push_back('{KIND_CLEAR, 10'($urandom)});
  endtask

  // wait for every transaction to finish, then let the sequencer go quiet
  task automatic settle();
    @(negedge clk);
    while (txn_q.size() != 0 || in_valid || delay_updates.size() != 0) @(negedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    case (idx)
      REG_SETPOINT:   sp_reg = val[SAMPLE_W-1:0];
      REG_TOTAL_GAIN: tg_reg = val;
      REG_PROP_GAIN:  pg_reg = val;
      REG_INTEG_GAIN: ig_reg = val;
      REG_DERIV_GAIN: dg_reg = val;
      REG_THRESHOLD:  thr_reg = val[SAMPLE_W-1:0];
      REG_PERIOD:     st_reg = val;
      REG_INV_PERIOD: ist_reg = val;
      default: ;
    endcase
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  // upper bits of the 10-bit registers get junk, which the block must drop
  task automatic write_all(input logic [SAMPLE_W-1:0] sp, input logic [GAIN_W-1:0] tg,
                           input logic [GAIN_W-1:0] pg, input logic [GAIN_W-1:0] ig,
                           input logic [GAIN_W-1:0] dg, input logic [SAMPLE_W-1:0] thr,
                           input logic [TIME_W-1:0] st, input logic [TIME_W-1:0] ist);
    write_reg(REG_SETPOINT, {6'($urandom), sp});
    write_reg(REG_TOTAL_GAIN, tg);
    write_reg(REG_PROP_GAIN, pg);
    write_reg(REG_INTEG_GAIN, ig);
    write_reg(REG_DERIV_GAIN, dg);
    write_reg(REG_THRESHOLD, {6'($urandom), thr});
    write_reg(REG_PERIOD, st);
    write_reg(REG_INV_PERIOD, ist);
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 6))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'($urandom);
      default: return 16'($urandom_range(0, 8192) - 4096);
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'd256;
      3: return 16'($urandom);
      default: return 16'($urandom_range(0, 1024));
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_level();
    case ($urandom_range(0, 3))
      0: return 10'h000;
      1: return 10'h3FF;
      default: return 10'($urandom);
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_band();
    case ($urandom_range(0, 4))
      0: return 10'h000;
      1: return 10'h3FF;
      2: return 10'($urandom);
      default: return 10'($urandom_range(1, 64));
    endcase
  endfunction

  task automatic queue_random(input logic [SAMPLE_W-1:0] sp, input logic [SAMPLE_W-1:0] thr);
    int v;
    int w;
    w = int'(thr) + 4;
    case ($urandom_range(0, 9))
      0: queue_clear();
      1: queue_step($urandom_range(0, 1) ? 10'h3FF : 10'h000);
      2, 3, 4: queue_step(10'($urandom));
      default: begin
        v = int'(sp) - w + int'($urandom_range(0, 2 * w));
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        queue_step(10'(v));
      end
    endcase
  endtask

  task automatic random_phase(input int n);
    logic [SAMPLE_W-1:0] sp;
    logic [SAMPLE_W-1:0] thr;
    sp = pick_level();
    thr = pick_band();
    write_all(sp, pick_gain(), pick_gain(), pick_gain(), pick_gain(), thr,
              pick_time(), pick_time());
    repeat (n) queue_random(sp, thr);
    settle();
  endtask

  // full-gain steps of one sign, each clamped to the correction limit
  task automatic push_run(input bit up);
    write_reg(REG_SETPOINT, up ? 16'h0000 : 16'h03FF);
    repeat (10) queue_step(up ? 10'($urandom_range(1, 1023)) : 10'($urandom_range(0, 1022)));
    settle();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset configuration: all gains zero
    queue_step(10'h000);
    queue_step(10'h3FF);
    queue_clear();
    queue_step(10'd700);
    settle();

    // unity gains, zero threshold: correction equals error, clamped
    write_all(10'd512, 16'h1000, 16'h1000, 16'h0000, 16'h0000, 10'd0, 16'd256, 16'd256);
    queue_step(10'd512);
    queue_step(10'd542);
    queue_step(10'd482);
    queue_step(10'h3FF);
    queue_step(10'h000);
    queue_clear();
    queue_step(10'd530);
    settle();

    // widest band, longest times, most negative total gain
    write_all(10'h3FF, 16'h8000, 16'h1000, 16'h1000, 16'h1000, 10'h3FF, 16'hFFFF, 16'hFFFF);
    queue_step(10'h000);
    queue_step(10'd1022);
    queue_step(10'h3FF);
    queue_clear();
    queue_step(10'd1000);
    settle();

    write_all(10'h000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 10'h3FF, 16'h0000, 16'h0000);
    queue_step(10'h3FF);
    queue_step(10'd1);
    queue_step(10'h000);
    queue_clear();
    queue_step(10'd1022);
    settle();

    repeat (4) random_phase(35);

    // long same-sign runs inside the band drive the integral into saturation
    write_all(10'd512, pick_gain(), pick_gain(), 16'($urandom_range(0, 64)), pick_gain(),
              10'h3FF, 16'hFFFF, pick_time());
    repeat (80) queue_step(10'(512 + $urandom_range(400, 511)));
    repeat (150) queue_step(10'(512 - $urandom_range(400, 512)));
    settle();

    repeat (4) random_phase(35);

    write_all(10'h3FF, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 10'd0, 16'd256, 16'd256);
    if (delay_acc >= 0) begin
      push_run(1'b1);
      push_run(1'b0);
    end else begin
      push_run(1'b0);
      push_run(1'b1);
    end

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
